[rtl/sbh_pkg.sv]
package sbh_pkg;

  // Source of the byte shifted into the block window.
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LEN_FIELD_START = 6'd56;
  localparam logic [5:0] LAST_SLOT      = 6'd63;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX  = 3'd7;

  localparam logic [31:0] K_TAB [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       shift_byte;
    logic [1:0] byte_src;
    logic [2:0] len_sel;
    logic       len_inc;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_hash;
    logic       init_msg;
    logic       out_load;
    logic [2:0] out_idx;
  } sbh_cmd_t;

  typedef struct packed {
    logic out_free;
  } sbh_status_t;

endpackage

[rtl/sbh_in_if.sv]
interface sbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_message, output ready);
endinterface

[rtl/sbh_out_if.sv]
interface sbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

[rtl/sha256_byte_stream_hasher.sv]
// SHA-256 hasher for a byte stream (FIPS 180-4).
// in_chan carries one beat per item: data_byte with byte_valid, and
// end_of_message. A beat with byte_valid set appends its byte; a beat with
// end_of_message set finishes the message after its byte, if any.
// out_chan returns the digest as eight 32-bit big-endian beats, word_index 0
// to 7, with last_word set on the eighth; nothing else is ever sent.
// A byte that does not complete a block leaves in_chan ready for the next.
// The 64th byte of a block starts the compression: 64 rounds, then a fold
// of the result into the hash words; in_chan is not ready again until the
// fold is done.
// An end of message shifts the padding in at one byte a cycle, compresses
// one or two blocks and offers the digest beats, one a cycle while out_chan
// is ready. If the block then holds 56 or more bytes, counting the end
// beat's byte, padding costs a second block; an end beat whose byte fills
// a block has that block compressed first.
// The digest sits in an output register; when the receiver stalls the
// current beat holds, and in_chan is taken again once the last word has
// been loaded into that register, even if it has not been collected yet.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the byte count, the block fill and the output valid flag.
module sha256_byte_stream_hasher #(
  parameter int LENGTH_COUNT_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  sbh_in_if.sink   in_chan,
  sbh_out_if.source out_chan
);
  import sbh_pkg::*;

  sbh_cmd_t    cmd;
  sbh_status_t status;

  // The controller owns the sequencing: block fill, padding phases,
  // the round counter and the digest word counter.
  sbh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_byte_valid     (in_chan.byte_valid),
    .in_end_of_message (in_chan.end_of_message),
    .in_ready          (in_chan.ready),
    .status            (status),
    .cmd               (cmd)
  );

  // The datapath holds the 512-bit block and schedule window, the working
  // variables, the hash words, the byte count and the output register.
  sbh_datapath #(
    .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .data_byte       (in_chan.data_byte),
    .out_ready       (out_chan.ready),
    .status          (status),
    .out_valid       (out_chan.valid),
    .out_digest_word (out_chan.digest_word),
    .out_word_index  (out_chan.word_index),
    .out_last_word   (out_chan.last_word)
  );

endmodule

[rtl/sbh_datapath.sv]
module sbh_datapath #(
  parameter int LENGTH_COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbh_pkg::sbh_cmd_t   cmd,
  input  logic [7:0]          data_byte,
  input  logic                out_ready,
  output sbh_pkg::sbh_status_t status,
  output logic                out_valid,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);
  import sbh_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Word 0 of the window sits in the top 32 bits; bytes enter at the bottom.
  logic [511:0]                 win_r;
  logic [31:0]                  v_r [0:7];
  logic [31:0]                  hash_r [0:7];
  logic [LENGTH_COUNT_BITS-1:0] len_r;
  logic                         out_valid_r;
  logic [31:0]                  out_word_r;
  logic [2:0]                   out_idx_r;
  logic                         out_last_r;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2;
  logic [63:0] bit_len;
  logic [7:0]  byte_in;

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];

  assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9 +
                 (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

  assign t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) +
              ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K_TAB[cmd.round_idx] + w0;
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // The bit length field is the byte count times eight, big-endian over 64 bits.
  assign bit_len = 64'(len_r) << 3;

  always_comb begin
    unique case (cmd.byte_src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PAD_BYTE;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = bit_len[(3'd7 - cmd.len_sel) * 8 +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      win_r <= {win_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      win_r <= {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round_en) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= IV_TAB[i];
      len_r <= '0;
    end else begin
      if (cmd.init_msg) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= IV_TAB[i];
        len_r <= '0;
      end else begin
        if (cmd.add_hash) begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
        end
        if (cmd.len_inc) begin
          len_r <= len_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= hash_r[cmd.out_idx];
      out_idx_r  <= cmd.out_idx;
      out_last_r <= (cmd.out_idx == LAST_WORD_IDX);
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  // A new word is only loaded when the held one is free to go.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("digest word overwritten before it was taken");

endmodule

[rtl/sbh_ctrl.sv]
module sbh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_byte_valid,
  input  logic                 in_end_of_message,
  output logic                 in_ready,
  input  sbh_pkg::sbh_status_t status,
  output sbh_pkg::sbh_cmd_t    cmd
);
  import sbh_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       pad80_done_r, pad80_done_nxt;
  logic       final_ok_r, final_ok_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    fill_nxt       = fill_r;
    rnd_nxt        = rnd_r;
    oidx_nxt       = oidx_r;
    pad80_done_nxt = pad80_done_r;
    final_ok_nxt   = final_ok_r;
    cmd            = '0;
    cmd.round_idx  = rnd_r;
    cmd.len_sel    = fill_r[2:0];
    cmd.out_idx    = oidx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pad80_done_nxt = 1'b0;
          final_ok_nxt   = 1'b0;
          if (in_byte_valid) begin
            cmd.shift_byte = 1'b1;
            cmd.byte_src   = SRC_DATA;
            cmd.len_inc    = 1'b1;
            fill_nxt       = fill_r + 6'd1;
            if (fill_r == LAST_SLOT) begin
              cmd.load_vars = 1'b1;
              rnd_nxt       = '0;
              state_nxt     = ST_ROUND;
              ret_nxt       = in_end_of_message ? ST_PAD : ST_IDLE;
            end else if (in_end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        fill_nxt       = fill_r + 6'd1;
        if (!pad80_done_r) begin
          cmd.byte_src   = SRC_PAD;
          pad80_done_nxt = 1'b1;
          if (fill_r < LEN_FIELD_START) final_ok_nxt = 1'b1;
        end else if (final_ok_r && fill_r >= LEN_FIELD_START) begin
          cmd.byte_src = SRC_LEN;
        end else begin
          cmd.byte_src = SRC_ZERO;
        end
        if (fill_r == LAST_SLOT) begin
          cmd.load_vars = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_ROUND;
          ret_nxt       = final_ok_r ? ST_OUT : ST_PAD;
          final_ok_nxt  = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.add_hash = 1'b1;
        oidx_nxt     = '0;
        state_nxt    = ret_r;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          oidx_nxt     = oidx_r + 3'd1;
          if (oidx_r == LAST_WORD_IDX) begin
            cmd.init_msg = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      fill_r       <= '0;
      rnd_r        <= '0;
      oidx_r       <= '0;
      pad80_done_r <= 1'b0;
      final_ok_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      fill_r       <= fill_nxt;
      rnd_r        <= rnd_nxt;
      oidx_r       <= oidx_nxt;
      pad80_done_r <= pad80_done_nxt;
      final_ok_r   <= final_ok_nxt;
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_ROUND) |=> (state_r == ST_FIN))
    else $error("compression did not finish after the last round");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_byte_valid && fill_r == LAST_SLOT) |=> (state_r == ST_ROUND))
    else $error("full block not compressed");

  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (fill_r == '0))
    else $error("block buffer not empty after compression");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && cmd.out_load && oidx_r == LAST_WORD_IDX) |=>
    (state_r == ST_IDLE && fill_r == '0))
    else $error("hasher not back to idle after the last digest word");

endmodule
